### hw/rtl/lfps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_pkg
// shared widths, types, register indexes and sensor weights for the
// proportional line-follow steering block
// ----------------------------------------------------------------------------
package lfps_pkg;

  localparam int unsigned SENSOR_LANES = 5;
  localparam int unsigned DUTY_W       = 10;
  localparam int unsigned KP_W         = 8;
  localparam int unsigned SUM_W        = 3;   // count of seen sensors, 0..5
  localparam int unsigned WSUM_W       = 3;   // signed weighted sum, -3..3
  localparam int unsigned NUM_W        = 13;  // numerator magnitude, up to 5115
  localparam int unsigned DIV_STEPS    = NUM_W;
  localparam int unsigned CNT_W        = $clog2(DIV_STEPS);
  localparam int unsigned CFG_IDX_W    = 2;

  localparam logic [KP_W-1:0]   KP_RST     = KP_W'(50);
  localparam logic [DUTY_W-1:0] BASE_RST   = DUTY_W'(650);
  localparam logic [DUTY_W-1:0] SEARCH_RST = DUTY_W'(250);
  localparam logic [DUTY_W-1:0] MAXD_RST   = DUTY_W'(1000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP         = 2'd0,
    CFG_BASE_SPEED = 2'd1,
    CFG_SEARCH     = 2'd2,
    CFG_MAX_DUTY   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_WRITE
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // capture item and form numerators
    logic step;      // one restoring divide step on both wheels
    logic out_load;  // write the result register
  } lfps_cmd_t;

  // weight of sensor lane i: -2 .. 2 from bit 0 to bit 4
  function automatic logic signed [WSUM_W-1:0] lane_weight(input int unsigned lane);
    logic signed [WSUM_W-1:0] w;
    unique case (lane)
      0:       w = -3'sd2;
      1:       w = -3'sd1;
      2:       w = 3'sd0;
      3:       w = 3'sd1;
      default: w = 3'sd2;
    endcase
    return w;
  endfunction

endpackage

### hw/rtl/lfps_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_in_if / lfps_out_if
// valid/ready channels carrying sensor items in and steering items out
// ----------------------------------------------------------------------------
interface lfps_in_if;
  logic       valid;
  logic       ready;
  logic [4:0] sensor_pins;
  logic       running;

  modport source (output valid, output sensor_pins, output running, input ready);
  modport sink   (input valid, input sensor_pins, input running, output ready);
endinterface

interface lfps_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] left_duty;
  logic [9:0] right_duty;
  logic       left_reverse;
  logic       right_reverse;
  logic       searching;

  modport source (output valid, output left_duty, output right_duty, output left_reverse,
                  output right_reverse, output searching, input ready);
  modport sink   (input valid, input left_duty, input right_duty, input left_reverse,
                  input right_reverse, input searching, output ready);
endinterface

### hw/rtl/lfps_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_ctrl
// sequencer: accept an item, run the divide steps, write the result
// ----------------------------------------------------------------------------
module lfps_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output lfps_pkg::lfps_cmd_t cmd_o
);

  lfps_pkg::state_e                state_q, state_d;
  logic [lfps_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic                            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lfps_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      lfps_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = lfps_pkg::ST_DIV;
        end
      end
      lfps_pkg::ST_DIV: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == lfps_pkg::CNT_W'(lfps_pkg::DIV_STEPS - 1)) begin
          state_d = lfps_pkg::ST_WRITE;
        end
      end
      lfps_pkg::ST_WRITE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = lfps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lfps_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // an accepted item always starts the divide
  a_accept_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == lfps_pkg::ST_DIV))
    else $error("accepted item did not start the divide");

  // a result only appears from the write state
  a_valid_from_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == lfps_pkg::ST_WRITE))
    else $error("result valid rose outside the write state");

  // the step counter stays inside the divide length
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lfps_pkg::ST_DIV) |-> (cnt_q < lfps_pkg::CNT_W'(lfps_pkg::DIV_STEPS)))
    else $error("divide step counter overran");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register written while still pending");

endmodule

### hw/rtl/lfps_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_dp
// config registers, numerator build, restoring divider and duty clamp
// ----------------------------------------------------------------------------
module lfps_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  lfps_pkg::lfps_cmd_t                    cmd_i,
  input  logic [lfps_pkg::SENSOR_LANES-1:0]      sensor_pins_i,
  input  logic                                   running_i,
  input  logic                                   cfg_we_i,
  input  logic [lfps_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [lfps_pkg::DUTY_W-1:0]            cfg_data_i,
  output logic [lfps_pkg::DUTY_W-1:0]            left_duty_o,
  output logic [lfps_pkg::DUTY_W-1:0]            right_duty_o,
  output logic                                   left_reverse_o,
  output logic                                   right_reverse_o,
  output logic                                   searching_o
);

  localparam int unsigned NW = lfps_pkg::NUM_W;
  localparam int unsigned SW = lfps_pkg::SUM_W;
  localparam int unsigned DW = lfps_pkg::DUTY_W;

  // config and control state
  logic [lfps_pkg::KP_W-1:0] kp_q;
  logic [DW-1:0]             base_q, search_q, maxd_q;
  logic                      last_pos_q;

  // per-item working registers
  logic          stop_q, lost_q, dir_pos_q;
  logic [SW-1:0] sum_q;
  logic [NW-1:0] lnum_q, rnum_q, lnum_d, rnum_d;
  logic [SW-1:0] lrem_q, rrem_q, lrem_d, rrem_d;
  logic          lneg_q, rneg_q;

  // result register
  logic [DW-1:0] left_duty_q, right_duty_q;
  logic          left_rev_q, right_rev_q, searching_q;

  // combinational numerator build
  logic [SW-1:0]            seen_cnt;
  logic signed [lfps_pkg::WSUM_W-1:0] wsum;
  logic [NW-1:0]            base_term;
  logic signed [NW:0]       kp_term, lnum_s, rnum_s;
  logic                     pos_err;

  always_comb begin
    seen_cnt = '0;
    wsum     = '0;
    for (int unsigned i = 0; i < lfps_pkg::SENSOR_LANES; i++) begin
      if (!sensor_pins_i[i]) begin
        seen_cnt = seen_cnt + 1'b1;
        wsum     = wsum + lfps_pkg::lane_weight(i);
      end
    end
    base_term = NW'(base_q) * NW'(seen_cnt);
    // both factors widened to the full signed width before the product
    kp_term   = $signed({{(NW - lfps_pkg::KP_W + 1){1'b0}}, kp_q}) *
                $signed({{(NW + 1 - lfps_pkg::WSUM_W){wsum[lfps_pkg::WSUM_W-1]}}, wsum});
    lnum_s    = $signed({1'b0, base_term}) + kp_term;
    rnum_s    = $signed({1'b0, base_term}) - kp_term;
    pos_err   = (wsum > 0);
  end

  function automatic logic [SW+NW-1:0] div_step(input logic [SW-1:0] rem,
                                                 input logic [NW-1:0] num,
                                                 input logic [SW-1:0] dvs);
    logic [SW:0] trial;
    logic        ge;
    logic [SW-1:0] rem_n;
    trial = {rem, num[NW-1]};
    ge    = (trial >= {1'b0, dvs});
    rem_n = ge ? SW'(trial - {1'b0, dvs}) : trial[SW-1:0];
    return {rem_n, num[NW-2:0], ge};
  endfunction

  always_comb begin
    {lrem_d, lnum_d} = div_step(lrem_q, lnum_q, sum_q);
    {rrem_d, rnum_d} = div_step(rrem_q, rnum_q, sum_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q       <= lfps_pkg::KP_RST;
      base_q     <= lfps_pkg::BASE_RST;
      search_q   <= lfps_pkg::SEARCH_RST;
      maxd_q     <= lfps_pkg::MAXD_RST;
      last_pos_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (lfps_pkg::cfg_idx_e'(cfg_idx_i))
          lfps_pkg::CFG_KP:         kp_q     <= cfg_data_i[lfps_pkg::KP_W-1:0];
          lfps_pkg::CFG_BASE_SPEED: base_q   <= cfg_data_i;
          lfps_pkg::CFG_SEARCH:     search_q <= cfg_data_i;
          lfps_pkg::CFG_MAX_DUTY:   maxd_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load && running_i && (seen_cnt != '0)) begin
        last_pos_q <= pos_err;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      stop_q    <= !running_i;
      lost_q    <= (seen_cnt == '0);
      dir_pos_q <= last_pos_q;
      sum_q     <= seen_cnt;
      lneg_q    <= lnum_s[NW];
      rneg_q    <= rnum_s[NW];
      lnum_q    <= lnum_s[NW] ? NW'(-lnum_s) : lnum_s[NW-1:0];
      rnum_q    <= rnum_s[NW] ? NW'(-rnum_s) : rnum_s[NW-1:0];
      lrem_q    <= '0;
      rrem_q    <= '0;
    end else if (cmd_i.step) begin
      lnum_q <= lnum_d;
      rnum_q <= rnum_d;
      lrem_q <= lrem_d;
      rrem_q <= rrem_d;
    end
  end

  // result selection and clamp
  logic [DW-1:0] search_d, lclamp, rclamp;
  always_comb begin
    search_d = (search_q > maxd_q) ? maxd_q : search_q;
    lclamp   = (lnum_q > NW'(maxd_q)) ? maxd_q : lnum_q[DW-1:0];
    rclamp   = (rnum_q > NW'(maxd_q)) ? maxd_q : rnum_q[DW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      priority if (stop_q) begin
        left_duty_q  <= '0;
        right_duty_q <= '0;
        left_rev_q   <= 1'b0;
        right_rev_q  <= 1'b0;
        searching_q  <= 1'b0;
      end else if (lost_q) begin
        left_duty_q  <= search_d;
        right_duty_q <= search_d;
        left_rev_q   <= !dir_pos_q;
        right_rev_q  <= dir_pos_q;
        searching_q  <= 1'b1;
      end else begin
        left_duty_q  <= lclamp;
        right_duty_q <= rclamp;
        left_rev_q   <= lneg_q && (lnum_q != '0);
        right_rev_q  <= rneg_q && (rnum_q != '0);
        searching_q  <= 1'b0;
      end
    end
  end

  assign left_duty_o     = left_duty_q;
  assign right_duty_o    = right_duty_q;
  assign left_reverse_o  = left_rev_q;
  assign right_reverse_o = right_rev_q;
  assign searching_o     = searching_q;

endmodule

### hw/rtl/line_follow_p_steering_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_follow_p_steering_top
// proportional steering for a two-wheel line follower
// ----------------------------------------------------------------------------
// Each item carries five active-low sensor pins and a run flag and yields one
// steering item: a duty magnitude and reverse flag per wheel plus a search
// flag. The accepting edge captures the item and builds the signed numerators,
// a restoring divider follows (one quotient bit per cycle for both wheels at
// once, over the 13-bit numerator magnitude), and the write state clamps and
// writes the result register. The block is idle again the cycle after, so a
// new item is accepted only once the previous one reaches the result register,
// even while that result still waits to be taken; the write cycle of the next
// item waits for it. Config writes (kp, base speed, search speed, max duty)
// take effect at once and are meant to be done while the block is idle.
module line_follow_p_steering_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  lfps_in_if.sink                         in_i,
  lfps_out_if.source                      out_o,
  input  logic                            cfg_we_i,
  input  logic [lfps_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lfps_pkg::DUTY_W-1:0]     cfg_data_i
);

  lfps_pkg::lfps_cmd_t cmd;

  // sequencer: handshakes and divide step count
  lfps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  // datapath: config, numerators, divider, clamp and result register
  lfps_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sensor_pins_i   (in_i.sensor_pins),
    .running_i       (in_i.running),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .left_duty_o     (out_o.left_duty),
    .right_duty_o    (out_o.right_duty),
    .left_reverse_o  (out_o.left_reverse),
    .right_reverse_o (out_o.right_reverse),
    .searching_o     (out_o.searching)
  );

endmodule

### tb/tb_line_follow_p_steering_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_follow_p_steering_top
// self-checking bench for the proportional line-follow steering block
// ----------------------------------------------------------------------------
// A queue-fed driver pushes sensor items into the block and a monitor checks
// every steering item against an in-bench steering predictor. The run opens
// with directed items at the reset settings. It then sweeps several register
// settings, extremes included, with random track-like and noise items. Both
// channels stall in random bursts except in one quiet phase and the last one.
// ----------------------------------------------------------------------------
module tb_line_follow_p_steering_top;

  localparam int unsigned WATCHDOG_LIMIT = 2000;  // far above the worst quiet stretch
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned MAX_PRINTS     = 100;
  localparam int unsigned RANDOM_ITEMS   = 120;   // per register setting
  localparam int unsigned N_SETTINGS     = 7;
  localparam int unsigned N_DIRECTED     = 20;

  typedef struct packed {
    logic [lfps_pkg::SENSOR_LANES-1:0] sensor_pins;
    logic                              running;
  } sensor_item_t;

  typedef struct packed {
    logic [lfps_pkg::DUTY_W-1:0] left_duty;
    logic [lfps_pkg::DUTY_W-1:0] right_duty;
    logic                        left_reverse;
    logic                        right_reverse;
    logic                        searching;
  } steer_item_t;

  // directed items, run at the reset settings
  localparam sensor_item_t DIRECTED [N_DIRECTED] = '{
    {5'b11111, 1'b1},  // line lost straight after reset: spin left
    {5'b11011, 1'b1},  // centered
    {5'b01111, 1'b1},  // far right sensor, positive error
    {5'b11111, 1'b1},  // line lost after positive error: spin right
    {5'b11111, 1'b0},  // stopped, no sensor
    {5'b00000, 1'b0},  // stopped, every sensor
    {5'b11110, 1'b1},  // far left sensor
    {5'b11111, 1'b1},  // lost after negative error: spin left
    {5'b11101, 1'b1},
    {5'b10111, 1'b1},
    {5'b11111, 1'b0},  // stop must leave the heading alone
    {5'b11111, 1'b1},  // so this one still spins right
    {5'b01110, 1'b1},  // outer pair balanced, clears the heading
    {5'b11111, 1'b1},  // spin left again
    {5'b00000, 1'b1},  // every sensor on the line
    {5'b11100, 1'b1},  // most negative weighted sum
    {5'b00111, 1'b1},  // most positive weighted sum
    {5'b10101, 1'b1},  // balanced inner pair
    {5'b01010, 1'b1},  // balanced three
    {5'b01111, 1'b1}
  };

  // register settings after the directed part: kp, base, search, max duty;
  // a negative entry draws a random value
  localparam int SETTINGS_TABLE [N_SETTINGS][4] = '{
    '{255, 1023, 1023, 1023},  // everything at the top
    '{0,   0,    0,    1},     // everything at the bottom, speeds all zero
    '{255, 0,    1023, 1},     // pure correction, reverse wheels, tight clamp
    '{1,   1023, 0,    0},     // max duty zero clamps every duty
    '{200, 100,  900,  500},   // mixed, speeds cross zero
    '{-1,  -1,   -1,   -1},
    '{50,  650,  250,  1000}   // back to reset values for the last part
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [lfps_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [lfps_pkg::DUTY_W-1:0] cfg_data;

  lfps_in_if  sensor_if ();
  lfps_out_if steer_if ();

  line_follow_p_steering_top u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (sensor_if),
    .out_o      (steer_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // predictor copy of the registers and the stored heading
  logic [lfps_pkg::KP_W-1:0]   kp_q;
  logic [lfps_pkg::DUTY_W-1:0] base_q;
  logic [lfps_pkg::DUTY_W-1:0] search_q;
  logic [lfps_pkg::DUTY_W-1:0] maxd_q;
  logic                        turn_right_q;  // last tracked error was positive

  sensor_item_t sensor_pending_q [$];
  steer_item_t  steer_expect_q [$];

  logic in_taken;      // sensor item accepted at the last rising edge
  bit   idle_on;       // random stalls allowed in this phase
  int   in_gap;
  int   out_stall;
  int   quiet_cycles;
  int   n_queued;
  int   n_items;
  int   n_results;
  int   n_errors;
  int   n_search;
  int   n_stop;
  int   n_reverse;
  int   n_settings_run;

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // duty magnitude of a signed wheel speed, clamped to max duty
  function automatic logic [lfps_pkg::DUTY_W-1:0] duty_mag(input int spd);
    int mag;
    int lim;
    mag = (spd < 0) ? -spd : spd;
    lim = maxd_q;
    return (mag > lim) ? lfps_pkg::DUTY_W'(lim) : lfps_pkg::DUTY_W'(mag);
  endfunction

  // expected steering for one sensor item; updates the stored heading
  function automatic steer_item_t predict_steer(input sensor_item_t it);
    steer_item_t res;
    int seen;
    int pos_err;
    int kp_v;
    int base_v;
    int lspd;
    int rspd;
    res     = '0;
    seen    = 0;
    pos_err = 0;
    kp_v    = kp_q;
    base_v  = base_q;
    // stopped: all zero, forward, heading untouched
    if (!it.running) return res;
    // pins are active low; lane weights run -2 .. 2 from bit 0
    for (int lane = 0; lane < lfps_pkg::SENSOR_LANES; lane++) begin
      if (!it.sensor_pins[lane]) begin
        seen++;
        pos_err += lane - 2;
      end
    end
    if (seen == 0) begin
      // line lost: spin toward the stored side, heading kept
      res.left_duty     = (search_q > maxd_q) ? maxd_q : search_q;
      res.right_duty    = res.left_duty;
      res.left_reverse  = !turn_right_q;
      res.right_reverse = turn_right_q;
      res.searching     = 1'b1;
      return res;
    end
    // SV integer divide truncates toward zero
    lspd = (base_v * seen + kp_v * pos_err) / seen;
    rspd = (base_v * seen - kp_v * pos_err) / seen;
    turn_right_q      = (pos_err > 0);
    res.left_duty     = duty_mag(lspd);
    res.right_duty    = duty_mag(rspd);
    res.left_reverse  = (lspd < 0);
    res.right_reverse = (rspd < 0);
    return res;
  endfunction

  // mostly track-like items, with lost lines, stops and raw noise mixed in
  function automatic sensor_item_t random_sensor_item();
    sensor_item_t it;
    int pick;
    int at;
    bit pair;
    it.running = ($urandom_range(0, 9) != 0);
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      it.sensor_pins = '1;
    end else if (pick < 6) begin
      // one sensor or two neighbors on the line
      pair = 1'($urandom_range(0, 1));
      at   = $urandom_range(0, 4 - int'(pair));
      it.sensor_pins = ~((pair ? 5'b00011 : 5'b00001) << at);
    end else begin
      it.sensor_pins = 5'($urandom());
    end
    return it;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    n_errors++;
    if (n_errors <= MAX_PRINTS)
      $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
  endtask

  // register write at a falling edge; predictor copy follows at once since
  // writes only happen with nothing in flight
  task automatic write_cfg(input lfps_pkg::cfg_idx_e idx, input int value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= lfps_pkg::DUTY_W'(value);
    case (idx)
      lfps_pkg::CFG_KP:         kp_q     = lfps_pkg::KP_W'(value);
      lfps_pkg::CFG_BASE_SPEED: base_q   = lfps_pkg::DUTY_W'(value);
      lfps_pkg::CFG_SEARCH:     search_q = lfps_pkg::DUTY_W'(value);
      default:                  maxd_q   = lfps_pkg::DUTY_W'(value);
    endcase
  endtask

  // wait for every queued item to come back, then let the block settle
  task automatic wait_drained();
    do @(negedge clk);
    while (n_results < n_queued);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // queue filled at a rising edge so it never races the driver
  task automatic queue_random(input int count, input bit stalls);
    @(posedge clk);
    idle_on = stalls;
    repeat (count) begin
      sensor_pending_q.push_back(random_sensor_item());
      n_queued++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // sensor driver: changes inputs at the falling edge, holds an item until
  // it is taken, then optionally idles for a burst
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : sensor_driver
    sensor_item_t nxt;
    if (!sensor_if.valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        sensor_if.valid <= 1'b0;
      end else if (sensor_pending_q.size() > 0) begin
        nxt = sensor_pending_q.pop_front();
        sensor_if.valid       <= 1'b1;
        sensor_if.sensor_pins <= nxt.sensor_pins;
        sensor_if.running     <= nxt.running;
        // gap after this item, drawn now so it lands on varied block phases
        if (idle_on && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 17);
      end else begin
        sensor_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // steering sink: ready drops in random bursts of stalled cycles
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : steer_ready_driver
    if (out_stall > 0) begin
      out_stall--;
      steer_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_stall = $urandom_range(0, 16);
      steer_if.ready <= 1'b0;
    end else begin
      steer_if.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks taken steering items first, then predicts for a taken
  // sensor item, all on the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : steer_monitor
    steer_item_t  got;
    steer_item_t  want;
    sensor_item_t seen_item;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= sensor_if.valid && sensor_if.ready;
      if (steer_if.valid && steer_if.ready) begin
        n_results++;
        got.left_duty     = steer_if.left_duty;
        got.right_duty    = steer_if.right_duty;
        got.left_reverse  = steer_if.left_reverse;
        got.right_reverse = steer_if.right_reverse;
        got.searching     = steer_if.searching;
        if (steer_expect_q.size() == 0) begin
          report_mismatch("steer item with none pending", 1, 0);
        end else begin
          want = steer_expect_q.pop_front();
          if (got.left_duty != want.left_duty)
            report_mismatch("left_duty", got.left_duty, want.left_duty);
          if (got.right_duty != want.right_duty)
            report_mismatch("right_duty", got.right_duty, want.right_duty);
          if (got.left_reverse != want.left_reverse)
            report_mismatch("left_reverse", got.left_reverse, want.left_reverse);
          if (got.right_reverse != want.right_reverse)
            report_mismatch("right_reverse", got.right_reverse, want.right_reverse);
          if (got.searching != want.searching)
            report_mismatch("searching", got.searching, want.searching);
        end
      end
      if (sensor_if.valid && sensor_if.ready) begin
        seen_item.sensor_pins = sensor_if.sensor_pins;
        seen_item.running     = sensor_if.running;
        want = predict_steer(seen_item);
        steer_expect_q.push_back(want);
        n_items++;
        if (!seen_item.running) n_stop++;
        if (want.searching) n_search++;
        if (!want.searching && (want.left_reverse || want.right_reverse)) n_reverse++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long with no item taken on either side ends the run
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watchdog
    if (!rst_n || (sensor_if.valid && sensor_if.ready) || (steer_if.valid && steer_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", quiet_cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence: reset, directed part, then one random phase per setting
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int val;
    // every block input known from time zero
    sensor_if.valid       = 1'b0;
    sensor_if.sensor_pins = '1;
    sensor_if.running     = 1'b0;
    steer_if.ready        = 1'b0;
    cfg_we                = 1'b0;
    cfg_idx               = lfps_pkg::CFG_KP;
    cfg_data              = '0;
    rst_n                 = 1'b0;
    kp_q                  = lfps_pkg::KP_RST;
    base_q                = lfps_pkg::BASE_RST;
    search_q              = lfps_pkg::SEARCH_RST;
    maxd_q                = lfps_pkg::MAXD_RST;
    turn_right_q          = 1'b0;
    idle_on               = 1'b0;
    in_gap                = 0;
    out_stall             = 0;
    n_queued              = 0;
    n_items               = 0;
    n_results             = 0;
    n_errors              = 0;
    n_search              = 0;
    n_stop                = 0;
    n_reverse             = 0;
    n_settings_run        = 1;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed items at the reset settings, with stalls
    @(posedge clk);
    idle_on = 1'b1;
    for (int k = 0; k < N_DIRECTED; k++) begin
      sensor_pending_q.push_back(DIRECTED[k]);
      n_queued++;
    end
    wait_drained();

    for (int ph = 0; ph < N_SETTINGS; ph++) begin
      // all four registers, written with the block idle
      for (int r = 0; r < 4; r++) begin
        val = SETTINGS_TABLE[ph][r];
        if (val < 0) begin
          case (lfps_pkg::cfg_idx_e'(r))
            lfps_pkg::CFG_KP:       val = $urandom_range(0, 255);
            lfps_pkg::CFG_MAX_DUTY: val = $urandom_range(1, 1023);
            default:                val = $urandom_range(0, 1023);
          endcase
        end
        write_cfg(lfps_pkg::cfg_idx_e'(r), val);
      end
      @(negedge clk);
      cfg_we <= 1'b0;
      n_settings_run++;
      // one quiet phase in the middle, and none at all at the end
      queue_random(RANDOM_ITEMS, (ph != 3) && (ph != N_SETTINGS - 1));
      wait_drained();
    end

    if (steer_expect_q.size() != 0)
      report_mismatch("steer items never seen", steer_expect_q.size(), 0);

    $display("run covered %0d sensor items over %0d register settings", n_items,
             n_settings_run);
    $display("%0d line searches, %0d stops, %0d items with a wheel in reverse, %0d mismatches",
             n_search, n_stop, n_reverse, n_errors);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
